// ----- design/vfom_pkg.sv -----
// Shared constants and types for the voxel face occlusion mask unit.
package vfom_pkg;

  // Voxels per chunk edge.
  localparam int CHUNK_SIZE = 16;
  // Voxels in one x plane.
  localparam int PLANE_LEN = CHUNK_SIZE * CHUNK_SIZE;
  // Bits of a coordinate within the chunk.
  localparam int CW = $clog2(CHUNK_SIZE);
  // Bits of an address into the plane memory.
  localparam int AW = $clog2(PLANE_LEN);
  // Bits of a coordinate field on the result port.
  localparam int FW = 4;
  // Bits of the face mask.
  localparam int MW = 6;

  // Raster position of a voxel within its chunk.
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } pos_t;

  // One plane memory entry: solid bit one plane back and two planes back.
  typedef struct packed {
    logic back2;
    logic back1;
  } plane_entry_t;

endpackage

// ----- design/vfom_raster.sv -----
// Raster position counter: z fastest, then y, then x, wrapping per chunk.
module vfom_raster (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  output vfom_pkg::pos_t    pos_o
);

  localparam logic [vfom_pkg::CW-1:0] Lim = vfom_pkg::CW'(vfom_pkg::CHUNK_SIZE - 1);

  vfom_pkg::pos_t pos_q;
  vfom_pkg::pos_t pos_d;

  always_comb begin
    pos_d = pos_q;
    if (adv_i) begin
      if (pos_q.z == Lim) begin
        pos_d.z = '0;
        if (pos_q.y == Lim) begin
          pos_d.y = '0;
          pos_d.x = (pos_q.x == Lim) ? '0 : pos_q.x + 1'b1;
        end else begin
          pos_d.y = pos_q.y + 1'b1;
        end
      end else begin
        pos_d.z = pos_q.z + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ----- design/vfom_plane_ram.sv -----
// Plane history memory: one write port, one registered read port.
module vfom_plane_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [vfom_pkg::AW-1:0]     waddr_i,
  input  vfom_pkg::plane_entry_t      wdata_i,
  input  logic                        re_i,
  input  logic [vfom_pkg::AW-1:0]     raddr_i,
  output vfom_pkg::plane_entry_t      rdata_o
);

  vfom_pkg::plane_entry_t mem_q [vfom_pkg::PLANE_LEN];
  vfom_pkg::plane_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/vfom_stencil.sv -----
// Neighbour taps around the previous plane and face mask assembly.
module vfom_stencil (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic                          solid_i,
  input  vfom_pkg::plane_entry_t        rd_data_i,
  output logic [vfom_pkg::MW-1:0]       face_mask_o,
  output vfom_pkg::plane_entry_t        wr_data_o
);

  localparam int S = vfom_pkg::CHUNK_SIZE;

  // Tap k of the one-plane line holds the voxel (PLANE_LEN - S + k + 1) items back
  // from the voxel in flight; the read data itself is tap minus one.
  logic [2*S-1:0] back1_q;
  logic [2*S-1:0] back1_d;
  logic [S-1:0]   back2_q;
  logic [S-1:0]   back2_d;

  assign back1_d = {back1_q[2*S-2:0], rd_data_i.back1};
  assign back2_d = {back2_q[S-2:0], rd_data_i.back2};

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      back1_q <= back1_d;
      back2_q <= back2_d;
    end
  end

  always_comb begin
    face_mask_o[0] = back1_q[S-2];      // +z
    face_mask_o[1] = solid_i;           // +x
    face_mask_o[2] = back1_q[S];        // -z
    face_mask_o[3] = back2_q[S-1];      // -x
    face_mask_o[4] = rd_data_i.back1;   // +y
    face_mask_o[5] = back1_q[2*S-1];    // -y
  end

  // The entry for this plane position becomes: newest bit, and the bit one plane back.
  assign wr_data_o.back1 = solid_i;
  assign wr_data_o.back2 = back1_q[S-1];

endmodule

// ----- design/voxel_face_occlusion_mask_unit.sv -----
// Top level: voxel stream in, six-neighbour face mask per interior voxel out.
// After the +x neighbour is accepted it passes the read stage, then the output register,
// before out_valid_o rises.
// Throughput: one voxel per cycle unless a held result stalls the input, set by the
// single read and single write port of the plane memory, each used once per voxel.
// Reset: position counter and pipeline valids clear; memory and tap lines are not
// cleared and need no clearing pass.
module voxel_face_occlusion_mask_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [15:0]               block_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [vfom_pkg::FW-1:0]   voxel_x_o,
  output logic [vfom_pkg::FW-1:0]   voxel_y_o,
  output logic [vfom_pkg::FW-1:0]   voxel_z_o,
  output logic [vfom_pkg::MW-1:0]   face_mask_o,
  output logic                      last_of_chunk_o
);

  localparam int CW = vfom_pkg::CW;
  localparam int FW = vfom_pkg::FW;
  localparam int AW = vfom_pkg::AW;
  localparam logic [CW-1:0] Lim   = CW'(vfom_pkg::CHUNK_SIZE - 1);
  localparam logic [CW-1:0] Inner = CW'(vfom_pkg::CHUNK_SIZE - 2);
  localparam logic [CW-1:0] One   = CW'(1);
  localparam logic [CW-1:0] Two   = CW'(2);

  vfom_pkg::pos_t         pos;
  vfom_pkg::plane_entry_t rd_data;
  vfom_pkg::plane_entry_t wr_data;
  logic [vfom_pkg::MW-1:0] mask;

  logic          accept;
  logic          s1_adv;
  logic          s1_res;
  logic          s1_last;
  logic          out_free;
  logic [CW-1:0] y_ahead;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // Read stage.
  logic                 v1_q;
  logic                 v1_d;
  vfom_pkg::pos_t       pos1_q;
  logic                 solid1_q;

  // Output register.
  logic                 vo_q;
  logic                 vo_d;
  logic [CW-1:0]        ox_q;
  logic [CW-1:0]        oy_q;
  logic [CW-1:0]        oz_q;
  logic [vfom_pkg::MW-1:0] omask_q;
  logic                 olast_q;

  logic [CW+FW-1:0]     ox_ext;
  logic [CW+FW-1:0]     oy_ext;
  logic [CW+FW-1:0]     oz_ext;

  vfom_raster u_raster (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (accept),
    .pos_o  (pos)
  );

  // Read the next row, wrapping; it holds the previous plane unless the read wrapped.
  assign y_ahead = (pos.y == Lim) ? '0 : pos.y + 1'b1;
  assign rd_addr = AW'(int'(y_ahead) * vfom_pkg::CHUNK_SIZE + int'(pos.z));
  assign wr_addr = AW'(int'(pos1_q.y) * vfom_pkg::CHUNK_SIZE + int'(pos1_q.z));

  vfom_plane_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  vfom_stencil u_stencil (
    .clk_i       (clk_i),
    .shift_i     (s1_adv),
    .solid_i     (solid1_q),
    .rd_data_i   (rd_data),
    .face_mask_o (mask),
    .wr_data_o   (wr_data)
  );

  // The voxel in the read stage is the +x neighbour of (x-1, y, z).
  assign s1_res = v1_q
               && (pos1_q.x >= Two) && (pos1_q.x <= Lim)
               && (pos1_q.y >= One) && (pos1_q.y <= Inner)
               && (pos1_q.z >= One) && (pos1_q.z <= Inner);
  assign s1_last = (pos1_q.x == Lim) && (pos1_q.y == Inner) && (pos1_q.z == Inner);

  assign out_free   = !vo_q || !out_stall_i;
  assign s1_adv     = v1_q && (!s1_res || out_free);
  assign in_stall_o = v1_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    v1_d = v1_q;
    if (accept) begin
      v1_d = 1'b1;
    end else if (s1_adv) begin
      v1_d = 1'b0;
    end
  end

  always_comb begin
    vo_d = vo_q;
    if (s1_adv && s1_res) begin
      vo_d = 1'b1;
    end else if (vo_q && !out_stall_i) begin
      vo_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      vo_q <= vo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos1_q   <= pos;
      solid1_q <= (block_value_i != 16'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_res) begin
      ox_q    <= pos1_q.x - 1'b1;
      oy_q    <= pos1_q.y;
      oz_q    <= pos1_q.z;
      omask_q <= mask;
      olast_q <= s1_last;
    end
  end

  // Fit coordinates to the field width: pad or keep the low bits.
  assign ox_ext = {{FW{1'b0}}, ox_q};
  assign oy_ext = {{FW{1'b0}}, oy_q};
  assign oz_ext = {{FW{1'b0}}, oz_q};

  assign out_valid_o     = vo_q;
  assign voxel_x_o       = ox_ext[FW-1:0];
  assign voxel_y_o       = oy_ext[FW-1:0];
  assign voxel_z_o       = oz_ext[FW-1:0];
  assign face_mask_o     = omask_q;
  assign last_of_chunk_o = olast_q;

  // The look-ahead read and the write-back never hit the same entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_adv) |-> (rd_addr != wr_addr))
    else $error("plane memory read and write collide");

  // The read stage only waits behind a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !s1_adv) |-> (vo_q && out_stall_i))
    else $error("read stage held without a blocked output");

  // A new result only ever comes from an occupied read stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v1_q))
    else $error("result appeared without a voxel in flight");

endmodule

// ----- bench/tb_voxel_face_occlusion_mask_unit.sv -----
// Self-checking bench for the voxel face occlusion mask unit, with handshake stalls.
module tb_voxel_face_occlusion_mask_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHUNK_SIZE  = vfom_pkg::CHUNK_SIZE;
  localparam int PLANE_LEN   = vfom_pkg::PLANE_LEN;
  localparam int FW          = vfom_pkg::FW;
  localparam int MW          = vfom_pkg::MW;
  localparam int HIST_DEPTH  = 2 * PLANE_LEN + 1;
  localparam int CHUNK_VOX   = PLANE_LEN * CHUNK_SIZE;
  // Masks start after two full planes and a row, so send a little over three planes.
  localparam int NUM_ITEMS   = 800;
  localparam int NUM_PHASES  = 4;
  localparam int DIRECT_BASE = PLANE_LEN + CHUNK_SIZE;
  localparam int NUM_DIRECT  = 24;

  typedef struct packed {
    logic [FW-1:0] x;
    logic [FW-1:0] y;
    logic [FW-1:0] z;
    logic [MW-1:0] mask;
    logic          last;
  } face_result_t;

  // Tracks the solid history and raster position, and holds the masks still owed by the unit.
  class face_mask_scoreboard;
    bit             solid_hist [HIST_DEPTH];
    int unsigned    wr_ptr;
    int unsigned    px, py, pz;
    face_result_t   owed_masks [$];
    int unsigned    errors;

    function bit solid_back(int unsigned back);
      return solid_hist[(wr_ptr + HIST_DEPTH - back) % HIST_DEPTH];
    endfunction

    function void note_voxel(logic [15:0] value);
      face_result_t want;
      int unsigned  lim;
      lim = CHUNK_SIZE - 1;
      solid_hist[wr_ptr] = (value != 16'd0);
      // The new voxel is the +x neighbour of the voxel one plane back.
      if (px >= 2 && px <= lim && py >= 1 && py < lim && pz >= 1 && pz < lim) begin
        want.x       = FW'(px - 1);
        want.y       = FW'(py);
        want.z       = FW'(pz);
        want.mask[0] = solid_back(PLANE_LEN - 1);
        want.mask[1] = solid_back(0);
        want.mask[2] = solid_back(PLANE_LEN + 1);
        want.mask[3] = solid_back(2 * PLANE_LEN);
        want.mask[4] = solid_back(PLANE_LEN - CHUNK_SIZE);
        want.mask[5] = solid_back(PLANE_LEN + CHUNK_SIZE);
        want.last    = (px == lim && py == lim - 1 && pz == lim - 1);
        owed_masks.push_back(want);
      end
      // Advance z fastest, then y, then x; wrap to the next chunk.
      if (pz >= lim) begin
        pz = 0;
        if (py >= lim) begin
          py = 0;
          px = (px >= lim) ? 0 : px + 1;
        end else begin
          py++;
        end
      end else begin
        pz++;
      end
      wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    endfunction

    function void check_result(face_result_t got);
      face_result_t want;
      if (owed_masks.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d mask=%b last=%b",
                 $time, got.x, got.y, got.z, got.mask, got.last);
        errors++;
        return;
      end
      want = owed_masks.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: voxel_x expected %0d, got %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: voxel_y expected %0d, got %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: voxel_z expected %0d, got %0d", $time, want.z, got.z);
        errors++;
      end
      if (got.mask !== want.mask) begin
        $display("%0t: face_mask at (%0d,%0d,%0d) expected %b, got %b",
                 $time, want.x, want.y, want.z, want.mask, got.mask);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_of_chunk at (%0d,%0d,%0d) expected %b, got %b",
                 $time, want.x, want.y, want.z, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [15:0]   block_value_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [FW-1:0] voxel_x_o;
  logic [FW-1:0] voxel_y_o;
  logic [FW-1:0] voxel_z_o;
  logic [MW-1:0] face_mask_o;
  logic          last_of_chunk_o;

  face_mask_scoreboard sb;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  int unsigned         plane_fill;
  logic [15:0]         edge_values [NUM_DIRECT];

  voxel_face_occlusion_mask_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .block_value_i  (block_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .voxel_x_o      (voxel_x_o),
    .voxel_y_o      (voxel_y_o),
    .voxel_z_o      (voxel_z_o),
    .face_mask_o    (face_mask_o),
    .last_of_chunk_o(last_of_chunk_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{voxel_x_o, voxel_y_o, voxel_z_o, face_mask_o, last_of_chunk_o});
    end
  end

  // Pick a fill density per x plane so that masks range from all clear to all set.
  function automatic logic [15:0] next_voxel(int unsigned idx);
    int unsigned in_chunk;
    in_chunk = idx % CHUNK_VOX;
    if (in_chunk >= DIRECT_BASE && in_chunk < DIRECT_BASE + NUM_DIRECT && idx < CHUNK_VOX) begin
      return edge_values[in_chunk - DIRECT_BASE];
    end
    if (idx % PLANE_LEN == 0) plane_fill = $urandom_range(5);
    case (plane_fill)
      0: return 16'd0;
      1: return 16'($urandom_range(1, 65535));
      2: return ($urandom_range(99) < 25) ? 16'($urandom_range(1, 65535)) : 16'd0;
      3: return ($urandom_range(99) < 50) ? 16'(1 << $urandom_range(15)) : 16'd0;
      4: return ($urandom_range(99) < 90) ? 16'($urandom_range(1, 65535)) : 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Hold the transaction until the unit takes it; leaves the bench at a falling edge.
  task automatic send_voxel(input logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    block_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_voxel(value);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned idx;
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    plane_fill     = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    block_value_i  = 16'd0;
    out_stall_i    = 1'b0;
    idx            = 0;

    // Extremes and walking ones, placed where they serve as neighbours of interior voxels.
    edge_values[0] = 16'h0000;
    edge_values[1] = 16'hFFFF;
    for (int k = 0; k < 16; k++) edge_values[2 + k] = 16'(1 << k);
    edge_values[18] = 16'h7FFF;
    edge_values[19] = 16'hFFFE;
    edge_values[20] = 16'h0000;
    edge_values[21] = 16'h0001;
    edge_values[22] = 16'h0000;
    edge_values[23] = 16'h8000;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int n = 0; n < NUM_ITEMS / NUM_PHASES; n++) begin
        send_voxel(next_voxel(idx));
        idx++;
      end
    end
    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;

    while (sb.owed_masks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("PASS voxel_face_occlusion_mask_unit");
    end else begin
      $display("FAIL voxel_face_occlusion_mask_unit");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL voxel_face_occlusion_mask_unit");
    $finish;
  end

endmodule

// ----- files.f -----
design/vfom_pkg.sv
design/vfom_raster.sv
design/vfom_plane_ram.sv
design/vfom_stencil.sv
design/voxel_face_occlusion_mask_unit.sv
bench/tb_voxel_face_occlusion_mask_unit.sv
